// ----- rtl/htfd_pkg.sv -----
// shared types, constants and crc function for the humidity/temperature frame decoder
package htfd_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } htfd_in_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        temperature_raw;
        logic [15:0]        humidity_raw;
        logic               temperature_check_ok;
        logic               humidity_check_ok;
    } htfd_out_t;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [15:0] FULL_SCALE  = 16'hFFFF;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;

    // crc-8, msb first, no final xor
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/humidity_temp_frame_decoder.sv -----
// humidity/temperature sensor frame decoder: crc check and fixed-point scaling
//
// Takes one frame byte per cycle unless the input stalls and, in the cycle after the sixth
// byte of a frame, presents a result holding both raw words, their crc-8 flags and the
// scaled values in hundredths. The input takes a byte in every cycle; it stalls only when a
// result is still waiting on the output register and the frame has reached its humidity crc
// byte, even if the waiting byte carries frame_start. All decoding runs in a single pass
// between the frame state registers and the output register; the scaling divides by 65535
// with a shift, an add and one correcting compare after a constant multiply.
module humidity_temp_frame_decoder (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  htfd_pkg::htfd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output htfd_pkg::htfd_out_t m_data
);

    localparam logic [2:0] POS_TEMP_HI = 3'd0;
    localparam logic [2:0] POS_TEMP_LO = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI = 3'd3;
    localparam logic [2:0] POS_HUM_LO = 3'd4;
    localparam logic [2:0] POS_HUM_CRC = 3'd5;

    logic [2:0]          byte_position_reg, byte_position_next;
    logic [7:0]          crc_reg, crc_next;
    logic [15:0]         temp_word_reg, temp_word_next;
    logic [15:0]         hum_word_reg, hum_word_next;
    logic                temp_ok_reg, temp_ok_next;
    logic                m_valid_reg, m_valid_next;
    htfd_pkg::htfd_out_t m_data_reg, m_data_next;

    logic       s_fire;
    logic [2:0] pos;
    logic       frame_done;

    // scaling datapath
    logic [30:0] temp_prod;
    logic [29:0] hum_prod;
    logic [16:0] temp_rem;
    logic [16:0] hum_rem;
    logic [14:0] temp_quot;
    logic [13:0] hum_quot;

    // only a byte in the humidity crc position waits for the output side
    assign s_ready = !m_valid_reg || m_ready || (byte_position_reg != POS_HUM_CRC);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (s_data.frame_start || byte_position_reg > POS_HUM_CRC) begin
            pos = POS_TEMP_HI;
        end else begin
            pos = byte_position_reg;
        end
    end

    assign frame_done = s_fire && (pos == POS_HUM_CRC);

    // x / 65535 = (x >> 16) plus one when the folded remainder reaches 65535
    assign temp_prod = 31'(temp_word_reg) * 31'(htfd_pkg::TEMP_SPAN);
    assign hum_prod  = 30'(hum_word_reg) * 30'(htfd_pkg::HUM_SPAN);
    assign temp_rem  = {1'b0, temp_prod[15:0]} + 17'(temp_prod[30:16]);
    assign hum_rem   = {1'b0, hum_prod[15:0]} + 17'(hum_prod[29:16]);
    assign temp_quot = temp_prod[30:16] + 15'(temp_rem >= 17'(htfd_pkg::FULL_SCALE));
    assign hum_quot  = hum_prod[29:16] + 14'(hum_rem >= 17'(htfd_pkg::FULL_SCALE));

    always_comb begin
        byte_position_next = byte_position_reg;
        crc_next           = crc_reg;
        temp_word_next     = temp_word_reg;
        hum_word_next      = hum_word_reg;
        temp_ok_next       = temp_ok_reg;
        if (s_fire) begin
            unique case (pos)
                POS_TEMP_HI: begin
                    crc_next           = htfd_pkg::crc8_update(htfd_pkg::CRC_INIT, s_data.rx_byte);
                    temp_word_next     = {s_data.rx_byte, 8'h00};
                    byte_position_next = POS_TEMP_LO;
                end
                POS_TEMP_LO: begin
                    crc_next           = htfd_pkg::crc8_update(crc_reg, s_data.rx_byte);
                    temp_word_next     = {temp_word_reg[15:8], s_data.rx_byte};
                    byte_position_next = POS_TEMP_CRC;
                end
                POS_TEMP_CRC: begin
                    temp_ok_next       = (s_data.rx_byte == crc_reg);
                    crc_next           = htfd_pkg::CRC_INIT;
                    byte_position_next = POS_HUM_HI;
                end
                POS_HUM_HI: begin
                    crc_next           = htfd_pkg::crc8_update(htfd_pkg::CRC_INIT, s_data.rx_byte);
                    hum_word_next      = {s_data.rx_byte, 8'h00};
                    byte_position_next = POS_HUM_LO;
                end
                POS_HUM_LO: begin
                    crc_next           = htfd_pkg::crc8_update(crc_reg, s_data.rx_byte);
                    hum_word_next      = {hum_word_reg[15:8], s_data.rx_byte};
                    byte_position_next = POS_HUM_CRC;
                end
                default: begin
                    crc_next           = htfd_pkg::CRC_INIT;
                    byte_position_next = POS_TEMP_HI;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (frame_done) begin
            m_valid_next                     = 1'b1;
            m_data_next.temperature_centi    = signed'(temp_quot - htfd_pkg::TEMP_OFFSET);
            m_data_next.humidity_centi       = hum_quot;
            m_data_next.temperature_raw      = temp_word_reg;
            m_data_next.humidity_raw         = hum_word_reg;
            m_data_next.temperature_check_ok = temp_ok_reg;
            m_data_next.humidity_check_ok    = (s_data.rx_byte == crc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg <= POS_TEMP_HI;
            crc_reg           <= htfd_pkg::CRC_INIT;
            m_valid_reg       <= 1'b0;
        end else begin
            byte_position_reg <= byte_position_next;
            crc_reg           <= crc_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        temp_word_reg <= temp_word_next;
        hum_word_reg  <= hum_word_next;
        temp_ok_reg   <= temp_ok_next;
        m_data_reg    <= m_data_next;
    end

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_position_reg <= POS_HUM_CRC)
        else $error("byte position out of range");

    a_crc_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_position_reg == POS_TEMP_HI || byte_position_reg == POS_HUM_HI)
        |-> crc_reg == htfd_pkg::CRC_INIT)
        else $error("crc not reinitialised at word start");

    a_frame_result: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> m_valid_reg && byte_position_reg == POS_TEMP_HI)
        else $error("completed frame did not produce a result");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid_reg && byte_position_reg == POS_HUM_CRC)
        else $error("input stalled without a pending result");

endmodule

// ----- dv/tb_humidity_temp_frame_decoder.sv -----
// testbench for the humidity/temperature frame decoder: frame traffic, crc flags and scaling
module tb_humidity_temp_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } frame_pos_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    htfd_pkg::htfd_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    htfd_pkg::htfd_out_t m_data;

    // decoder state as seen from the input stream
    frame_pos_t  next_pos;
    logic [7:0]  running_crc;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        temp_crc_ok;

    htfd_pkg::htfd_out_t expected_readings[$];

    int error_count;
    int bytes_accepted;
    int send_idle_pct;
    int recv_stall_pct;

    humidity_temp_frame_decoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // bitwise crc-8, msb first
    function automatic logic [7:0] crc8_fold(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c  = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // advance the predicted decoder by one accepted byte
    task automatic advance_frame_decode(input htfd_pkg::htfd_in_t item);
        frame_pos_t          pos;
        htfd_pkg::htfd_out_t reading;
        logic [31:0]         t_scaled;
        logic [31:0]         h_scaled;
        pos = item.frame_start ? POS_T_HI : next_pos;
        case (pos)
            POS_T_HI: begin
                running_crc = crc8_fold(htfd_pkg::CRC_INIT, item.rx_byte);
                temp_word   = {item.rx_byte, 8'h00};
                next_pos    = POS_T_LO;
            end
            POS_T_LO: begin
                running_crc = crc8_fold(running_crc, item.rx_byte);
                temp_word   = {temp_word[15:8], item.rx_byte};
                next_pos    = POS_T_CRC;
            end
            POS_T_CRC: begin
                temp_crc_ok = (item.rx_byte == running_crc);
                running_crc = htfd_pkg::CRC_INIT;
                next_pos    = POS_H_HI;
            end
            POS_H_HI: begin
                running_crc = crc8_fold(htfd_pkg::CRC_INIT, item.rx_byte);
                hum_word    = {item.rx_byte, 8'h00};
                next_pos    = POS_H_LO;
            end
            POS_H_LO: begin
                running_crc = crc8_fold(running_crc, item.rx_byte);
                hum_word    = {hum_word[15:8], item.rx_byte};
                next_pos    = POS_H_CRC;
            end
            default: begin
                t_scaled = (32'(htfd_pkg::TEMP_SPAN) * 32'(temp_word))
                           / 32'(htfd_pkg::FULL_SCALE);
                h_scaled = (32'(htfd_pkg::HUM_SPAN) * 32'(hum_word))
                           / 32'(htfd_pkg::FULL_SCALE);
                reading.temperature_centi    = 15'(t_scaled - 32'(htfd_pkg::TEMP_OFFSET));
                reading.humidity_centi       = 14'(h_scaled);
                reading.temperature_raw      = temp_word;
                reading.humidity_raw         = hum_word;
                reading.temperature_check_ok = temp_crc_ok;
                reading.humidity_check_ok    = (item.rx_byte == running_crc);
                expected_readings.push_back(reading);
                running_crc = htfd_pkg::CRC_INIT;
                next_pos    = POS_T_HI;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fs);
        htfd_pkg::htfd_in_t item;
        item.rx_byte     = b;
        item.frame_start = fs;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_frame_decode(item);
        bytes_accepted++;
    endtask

    // sends the first n_bytes of a frame; bad flags corrupt the matching crc byte
    task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input bit t_bad,
                              input bit h_bad, input logic fs, input int n_bytes);
        logic [7:0] frame_bytes[6];
        frame_bytes[0] = tw[15:8];
        frame_bytes[1] = tw[7:0];
        frame_bytes[2] = crc8_fold(crc8_fold(htfd_pkg::CRC_INIT, tw[15:8]), tw[7:0]);
        frame_bytes[3] = hw[15:8];
        frame_bytes[4] = hw[7:0];
        frame_bytes[5] = crc8_fold(crc8_fold(htfd_pkg::CRC_INIT, hw[15:8]), hw[7:0]);
        if (t_bad) frame_bytes[2] ^= 8'($urandom_range(255, 1));
        if (h_bad) frame_bytes[5] ^= 8'($urandom_range(255, 1));
        for (int i = 0; i < n_bytes; i++) begin
            send_byte(frame_bytes[i], (i == 0) ? fs : 1'b0);
        end
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            4:       return 16'h0001;
            5:       return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_extreme_words();
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, 6);
    endtask

    task automatic test_crc_failures();
        // follows straight on without frame_start
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 6);
    endtask

    task automatic test_resync();
        // stop one byte short, then restart: the partial frame must vanish
        send_frame(16'h1234, 16'h5678, 1'b0, 1'b0, 1'b1, 5);
        send_frame(16'hBEEF, 16'h8000, 1'b0, 1'b1, 1'b1, 6);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int   stop_at;
        int   pick;
        logic fs;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = bytes_accepted + n_items;
        while (bytes_accepted < stop_at) begin
            pick = $urandom_range(99);
            fs   = (next_pos != POS_T_HI) || ($urandom_range(3) != 0);
            if (pick < 80) begin
                send_frame(pick_word(), pick_word(), $urandom_range(9) == 0,
                           $urandom_range(9) == 0, fs, 6);
            end else if (pick < 90) begin
                send_frame(pick_word(), pick_word(), 1'b0, 1'b0, 1'b1,
                           $urandom_range(5, 1));
            end else begin
                send_byte(8'($urandom), 1'($urandom));
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        htfd_pkg::htfd_out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_readings.size() == 0) begin
                report_error("result transaction with nothing expected");
            end else begin
                want = expected_readings.pop_front();
                if (m_data.temperature_centi !== want.temperature_centi)
                    report_error($sformatf("temperature_centi got %0d want %0d",
                        m_data.temperature_centi, want.temperature_centi));
                if (m_data.humidity_centi !== want.humidity_centi)
                    report_error($sformatf("humidity_centi got %0d want %0d",
                        m_data.humidity_centi, want.humidity_centi));
                if (m_data.temperature_raw !== want.temperature_raw)
                    report_error($sformatf("temperature_raw got %h want %h",
                        m_data.temperature_raw, want.temperature_raw));
                if (m_data.humidity_raw !== want.humidity_raw)
                    report_error($sformatf("humidity_raw got %h want %h",
                        m_data.humidity_raw, want.humidity_raw));
                if (m_data.temperature_check_ok !== want.temperature_check_ok)
                    report_error($sformatf("temperature_check_ok got %b want %b",
                        m_data.temperature_check_ok, want.temperature_check_ok));
                if (m_data.humidity_check_ok !== want.humidity_check_ok)
                    report_error($sformatf("humidity_check_ok got %b want %b",
                        m_data.humidity_check_ok, want.humidity_check_ok));
            end
        end
    end

    initial begin
        error_count    = 0;
        bytes_accepted = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        next_pos       = POS_T_HI;
        running_crc    = htfd_pkg::CRC_INIT;
        temp_word      = '0;
        hum_word       = '0;
        temp_crc_ok    = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        m_ready <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extreme_words();
        test_crc_failures();
        test_resync();
        test_random_traffic(220, 0, 0);
        test_random_traffic(210, 67, 0);
        test_random_traffic(210, 0, 67);
        test_random_traffic(210, 9, 9);

        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
